// ===== src/mbrtu_pkg.sv =====
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared types, constants and helper functions for the Modbus RTU slave
// register engine.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

	// Register space and buffer sizing.
	localparam int REGION_SIZE        = 256;
	localparam int PAYLOAD_MAX        = 256;
	localparam int MAX_RESPONSE_BYTES = 64;

	localparam int RA_W    = $clog2(REGION_SIZE);   // index inside one region
	localparam int REG_W   = RA_W + 2;              // register number, four regions
	localparam int END_W   = REG_W + 1;             // end of range, may equal space end
	localparam int SIZE_W  = REG_W + 2;             // data bytes of a range
	localparam int PL_AW   = $clog2(PAYLOAD_MAX);   // payload buffer address
	localparam int PL_CW   = PL_AW + 1;             // payload byte count
	localparam int POS_W   = 9;                     // frame byte position
	localparam int SPACE_END = 4 * REGION_SIZE;

	// Frame layout.
	localparam logic [POS_W-1:0] POS_ID    = 9'd0;
	localparam logic [POS_W-1:0] POS_FC    = 9'd1;
	localparam logic [POS_W-1:0] POS_SH    = 9'd2;
	localparam logic [POS_W-1:0] POS_SL    = 9'd3;
	localparam logic [POS_W-1:0] POS_NH    = 9'd4;
	localparam logic [POS_W-1:0] POS_NL    = 9'd5;
	localparam logic [POS_W-1:0] POS_BC    = 9'd6;
	localparam logic [POS_W-1:0] HDR_LEN   = 9'd7;
	localparam logic [POS_W-1:0] RD_CRC_AT = 9'd6;

	// Function codes and reply id.
	localparam logic [7:0] FC_READ  = 8'h03;
	localparam logic [7:0] FC_WRITE = 8'h10;
	localparam logic [7:0] REPLY_ID = 8'h00;

	// CRC-16/MODBUS.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Queue depths (powers of two).
	localparam int CMDQ_DEPTH = 2;
	localparam int OUTQ_DEPTH = 4;

	// Items on the two channels.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} req_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_last;
	} resp_item_t;

	// A checked request handed from the parser to the executor.
	typedef struct packed {
		logic              is_wr;
		logic [REG_W-1:0]  start;
		logic [REG_W-1:0]  count;
		logic [END_W-1:0]  stop;
		logic [SIZE_W-1:0] size;
	} cmd_t;

	// Executor status seen by the parser.
	typedef struct packed {
		logic clearing;
		logic wr_busy;
	} back_stat_t;

	typedef enum logic [3:0] {
		BS_CLEAR,
		BS_IDLE,
		BS_WR_CHECK,
		BS_WR_FETCH,
		BS_WR_CAPT,
		BS_WR_STORE,
		BS_HDR,
		BS_RD_CHECK,
		BS_RD_DATA,
		BS_RD_EMIT,
		BS_CRC_LO,
		BS_CRC_HI
	} b_state_t;

	// Bytes per register in each region: words, floats, bytes, flags.
	function automatic logic [2:0] region_bytes(input logic [1:0] k);
		logic [2:0] w;
		unique case (k)
			2'd0:    w = 3'd2;
			2'd1:    w = 3'd4;
			default: w = 3'd1;
		endcase
		return w;
	endfunction

	// One byte through the reflected CRC-16/MODBUS.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Data bytes covered by registers [s, e) across the four regions.
	function automatic logic [SIZE_W-1:0] data_size(input logic [REG_W-1:0] s,
			input logic [END_W-1:0] e);
		logic [SIZE_W-1:0] t;
		logic [END_W-1:0]  lo;
		logic [END_W-1:0]  hi;
		logic [END_W-1:0]  a;
		logic [END_W-1:0]  z;
		t = '0;
		for (int k = 0; k < 4; k++) begin
			lo = END_W'(k * REGION_SIZE);
			hi = END_W'((k + 1) * REGION_SIZE);
			a  = ({1'b0, s} > lo) ? {1'b0, s} : lo;
			z  = (e < hi) ? e : hi;
			if (z > a) begin
				t = t + SIZE_W'(SIZE_W'(z - a) * SIZE_W'(region_bytes(2'(k))));
			end
		end
		return t;
	endfunction

endpackage

// ===== src/modbus_rtu_slave_register_engine.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_slave_register_engine
// Modbus RTU slave for read registers (0x03) and write registers (0x10).
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter as items on the req queue port (push/full), each with
// a frame_start mark on the first byte after line idle. Response bytes leave
// on the resp queue port (empty/pop), oldest first, tx_last on the final CRC
// byte. node_address is written through node_we/node_wdata while idle.
// The parser takes a new request byte whenever full is low. After the last
// CRC byte the executor commits a write by fetching each payload byte and
// storing each register, then emits the response bytes, reading each
// register before its bytes on a read. A read response starts once its
// request leaves the request queue; a write response follows its commit.
// While a write is queued or committing, full stays high, since the payload
// buffer has a single write and read port.
// After reset the four register stores are swept to zero at every address;
// full is high for that time. Bad frames produce nothing and are ignored up
// to the next frame start. When the receiver stops popping, the output queue
// fills, the executor waits, and full rises once the request queue fills.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_register_engine
	import mbrtu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       node_we,
	input  logic [7:0] node_wdata,
	input  logic       push,
	input  req_item_t  req,
	output logic       full,
	input  logic       pop,
	output resp_item_t resp,
	output logic       empty
);

	back_stat_t       back_stat;
	logic             cmdq_full;
	logic             cmdq_has_wr;
	logic             cmdq_valid;
	logic             cmd_push;
	logic             cmd_pop;
	cmd_t             cmd_in;
	cmd_t             cmd_out;
	logic             pl_we;
	logic [PL_AW-1:0] pl_waddr;
	logic [7:0]       pl_wdata;
	logic [PL_AW-1:0] pl_raddr;
	logic [7:0]       pl_rdata;
	logic             outq_full;
	logic             out_push;
	resp_item_t       out_item;

	// Parser.
	mbrtu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.node_we     (node_we),
		.node_wdata  (node_wdata),
		.push        (push),
		.req         (req),
		.full        (full),
		.back_stat   (back_stat),
		.cmdq_full   (cmdq_full),
		.cmdq_has_wr (cmdq_has_wr),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in),
		.pl_we       (pl_we),
		.pl_waddr    (pl_waddr),
		.pl_wdata    (pl_wdata)
	);

	// Write data of the current frame.
	mbrtu_ram #(.WIDTH(8), .DEPTH(PAYLOAD_MAX)) u_payload (
		.clk   (clk),
		.we    (pl_we),
		.waddr (pl_waddr),
		.wdata (pl_wdata),
		.raddr (pl_raddr),
		.rdata (pl_rdata)
	);

	// Checked requests.
	mbrtu_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.valid  (cmdq_valid),
		.full   (cmdq_full),
		.has_wr (cmdq_has_wr)
	);

	// Executor and register stores.
	mbrtu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmdq_valid),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.pl_raddr  (pl_raddr),
		.pl_rdata  (pl_rdata),
		.outq_full (outq_full),
		.out_push  (out_push),
		.out_item  (out_item),
		.stat      (back_stat)
	);

	// Response items.
	mbrtu_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (out_item),
		.full   (outq_full),
		.pop    (pop),
		.dout   (resp),
		.empty  (empty)
	);

endmodule

// ===== src/mbrtu_ram.sv =====
// ----------------------------------------------------------------------------
// mbrtu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbrtu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/mbrtu_front.sv =====
// ----------------------------------------------------------------------------
// mbrtu_front
// Frame parser: checks id, function, address bytes, byte count and CRC,
// stores write data in the payload buffer and queues checked requests.
// ----------------------------------------------------------------------------
module mbrtu_front
	import mbrtu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             node_we,
	input  logic [7:0]       node_wdata,
	input  logic             push,
	input  req_item_t        req,
	output logic             full,
	input  back_stat_t       back_stat,
	input  logic             cmdq_full,
	input  logic             cmdq_has_wr,
	output logic             cmd_push,
	output cmd_t             cmd,
	output logic             pl_we,
	output logic [PL_AW-1:0] pl_waddr,
	output logic [7:0]       pl_wdata
);

	logic [7:0]       node_q;
	logic             drop_q;
	logic [POS_W-1:0] pos_q;
	logic [15:0]      crc_q;
	logic [7:0]       fc_q;
	logic [7:0]       sh_q, sl_q, nh_q, nl_q, bc_q;

	logic             drop_d;
	logic [POS_W-1:0] pos_d;
	logic [15:0]      crc_d;
	logic [7:0]       fc_d;

	logic             acc;
	logic [7:0]       b;
	logic             eff_drop;
	logic [POS_W-1:0] p;
	logic [15:0]      crc;
	logic [7:0]       fc;
	logic [REG_W-1:0] start;
	logic [REG_W-1:0] count;
	logic [END_W-1:0] sum;
	logic [END_W-1:0] stop;
	logic [SIZE_W-1:0] size;
	logic             bad;
	logic [POS_W-1:0] limit;
	logic [POS_W-1:0] pl_off;

	// The payload buffer and the queue are shared with the executor, so hold
	// off while a write is queued or being committed.
	assign full = back_stat.clearing | back_stat.wr_busy | cmdq_full | cmdq_has_wr;
	assign acc  = push & ~full;
	assign b    = req.rx_byte;

	// A frame start restarts parsing for this byte.
	assign eff_drop = req.frame_start ? 1'b0 : drop_q;
	assign p        = req.frame_start ? '0 : pos_q;
	assign crc      = req.frame_start ? CRC_INIT : crc_q;
	assign fc       = (p == POS_FC) ? b : (req.frame_start ? 8'h00 : fc_q);

	// Register range of the frame, end clipped to the register space.
	assign start = {sh_q[1:0], sl_q};
	assign count = {nh_q[1:0], nl_q};
	assign sum   = END_W'({1'b0, start} + {1'b0, count});
	assign stop  = (sum > END_W'(SPACE_END)) ? END_W'(SPACE_END) : sum;
	assign size  = data_size(start, stop);

	// Header checks.
	assign bad = ((p == POS_ID) && (b != node_q))
		|| ((p == POS_FC) && (b != FC_READ) && (b != FC_WRITE))
		|| (((p == POS_SH) || (p == POS_NH)) && (b >= 8'd4))
		|| ((p == POS_BC) && (fc == FC_WRITE)
			&& ((size != SIZE_W'(b)) || ({1'b0, b} > 9'(PAYLOAD_MAX))));

	// Position of the CRC low byte.
	assign limit = (fc == FC_READ) ? RD_CRC_AT
		: ((p < HDR_LEN) ? HDR_LEN : POS_W'(HDR_LEN + {1'b0, bc_q}));

	assign pl_off   = POS_W'(p - HDR_LEN);
	assign pl_waddr = pl_off[PL_AW-1:0];
	assign pl_wdata = b;

	assign cmd.is_wr = (fc_q == FC_WRITE);
	assign cmd.start = start;
	assign cmd.count = count;
	assign cmd.stop  = stop;
	assign cmd.size  = size;

	// Next parser state for an accepted item.
	always_comb begin
		drop_d   = drop_q;
		pos_d    = pos_q;
		crc_d    = crc_q;
		fc_d     = fc_q;
		cmd_push = 1'b0;
		pl_we    = 1'b0;
		if (acc) begin
			drop_d = eff_drop;
			pos_d  = p;
			crc_d  = crc;
			fc_d   = req.frame_start ? 8'h00 : fc_q;
			if (!eff_drop) begin
				if (p == POS_FC) begin
					fc_d = b;
				end
				if (bad) begin
					drop_d = 1'b1;
				end else begin
					pos_d = POS_W'(p + 9'd1);
					if (p < limit) begin
						crc_d = crc_byte(crc, b);
						pl_we = (fc == FC_WRITE) && (p >= HDR_LEN);
					end else if (p == limit) begin
						if (b != crc[7:0]) begin
							drop_d = 1'b1;
						end
					end else begin
						drop_d   = 1'b1;
						cmd_push = (b == crc[15:8]);
					end
				end
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= 8'h00;
			drop_q <= 1'b1;
			pos_q  <= '0;
			crc_q  <= CRC_INIT;
			fc_q   <= 8'h00;
		end else begin
			if (node_we) begin
				node_q <= node_wdata;
			end
			drop_q <= drop_d;
			pos_q  <= pos_d;
			crc_q  <= crc_d;
			fc_q   <= fc_d;
		end
	end

	// Header bytes of the current frame.
	always_ff @(posedge clk) begin
		if (acc && !eff_drop) begin
			unique case (p)
				POS_SH:  sh_q <= b;
				POS_SL:  sl_q <= b;
				POS_NH:  nh_q <= b;
				POS_NL:  nl_q <= b;
				POS_BC:  bc_q <= b;
				default: ;
			endcase
		end
	end

	// A completed frame always leaves the parser waiting for a frame start.
	a_push_drops: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |=> drop_q)
		else $error("parser still live after a completed frame");

	// Payload bytes only come from a frame that is still being parsed.
	a_pl_live: assert property (@(posedge clk) disable iff (!arst_n)
		pl_we |=> !drop_q)
		else $error("payload written by a dropped frame");

	// The queue is never pushed while full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmdq_full)
		else $error("request pushed into a full queue");

endmodule

// ===== src/mbrtu_cmdq.sv =====
// ----------------------------------------------------------------------------
// mbrtu_cmdq
// Short queue of checked requests between the parser and the executor.
// ----------------------------------------------------------------------------
module mbrtu_cmdq
	import mbrtu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	input  logic pop,
	output cmd_t dout,
	output logic valid,
	output logic full,
	output logic has_wr
);

	localparam int AW = $clog2(CMDQ_DEPTH);

	cmd_t            ent_q [CMDQ_DEPTH];
	logic [AW-1:0]   rd_q;
	logic [AW-1:0]   wr_q;
	logic [AW:0]     cnt_q;
	logic            do_push;
	logic            do_pop;
	logic [AW:0]     age;

	assign valid   = (cnt_q != '0);
	assign full    = (cnt_q == (AW+1)'(CMDQ_DEPTH));
	assign do_push = push & ~full;
	assign do_pop  = pop & valid;
	assign dout    = ent_q[rd_q];

	// Any write request among the waiting entries.
	always_comb begin
		has_wr = 1'b0;
		for (int i = 0; i < CMDQ_DEPTH; i++) begin
			age = (AW+1)'(AW'(AW'(i) - rd_q));
			if (age < cnt_q) begin
				has_wr = has_wr | ent_q[i].is_wr;
			end
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= AW'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= AW'(rd_q + 1'b1);
			end
			cnt_q <= (AW+1)'(cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop));
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= din;
		end
	end

endmodule

// ===== src/mbrtu_back.sv =====
// ----------------------------------------------------------------------------
// mbrtu_back
// Executor: clears the register stores after reset, commits writes from the
// payload buffer and builds response frames with their CRC.
// ----------------------------------------------------------------------------
module mbrtu_back
	import mbrtu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	output logic [PL_AW-1:0] pl_raddr,
	input  logic [7:0]       pl_rdata,
	input  logic             outq_full,
	output logic             out_push,
	output resp_item_t       out_item,
	output back_stat_t       stat
);

	b_state_t          state_q, state_d;
	logic [RA_W-1:0]   clr_q;
	cmd_t              cmd_q;
	logic [END_W-1:0]  r_q;
	logic [PL_CW-1:0]  p_q;
	logic [2:0]        j_q;
	logic [31:0]       acc_q;
	logic [15:0]       crc_q;
	logic [2:0]        h_q;

	logic [1:0]        k;
	logic [2:0]        wb;
	logic              wr_fits;
	logic              more;
	logic              hdr_last;
	logic              byte_last;
	logic              too_long;
	logic              clearing;

	logic              emit_valid;
	logic [7:0]        emit_byte;
	logic              emit_last;
	logic [7:0]        hdr_byte;
	logic [3:0]        st_we;

	logic [RA_W-1:0]   st_waddr;
	logic [RA_W-1:0]   st_raddr;
	logic [15:0]       word_rd;
	logic [31:0]       float_rd;
	logic [7:0]        byte_rd;
	logic [0:0]        flag_rd;

	assign k         = r_q[REG_W-1:RA_W];
	assign wb        = region_bytes(k);
	assign wr_fits   = ((PL_CW+1)'({1'b0, p_q} + (PL_CW+1)'(wb)))
		<= (PL_CW+1)'(PAYLOAD_MAX);
	assign more      = (r_q < cmd_q.stop);
	assign hdr_last  = cmd_q.is_wr ? (h_q == 3'd5) : (h_q == 3'd2);
	assign byte_last = (3'(j_q + 3'd1) == wb);
	assign too_long  = ((SIZE_W+1)'({1'b0, cmd.size} + (SIZE_W+1)'(5)))
		> (SIZE_W+1)'(MAX_RESPONSE_BYTES);
	assign clearing  = (state_q == BS_CLEAR);

	assign stat.clearing = clearing;
	assign stat.wr_busy  = (state_q == BS_WR_CHECK) || (state_q == BS_WR_FETCH)
		|| (state_q == BS_WR_CAPT) || (state_q == BS_WR_STORE);

	// Header bytes of the response.
	always_comb begin
		unique case (h_q)
			3'd0:    hdr_byte = REPLY_ID;
			3'd1:    hdr_byte = cmd_q.is_wr ? FC_WRITE : FC_READ;
			3'd2:    hdr_byte = cmd_q.is_wr ? 8'(cmd_q.start >> 8) : cmd_q.size[7:0];
			3'd3:    hdr_byte = cmd_q.start[7:0];
			3'd4:    hdr_byte = 8'(cmd_q.count >> 8);
			default: hdr_byte = cmd_q.count[7:0];
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BS_CLEAR:    if (clr_q == RA_W'(REGION_SIZE - 1)) state_d = BS_IDLE;
			BS_IDLE: begin
				if (cmd_valid) begin
					if (cmd.is_wr) begin
						state_d = BS_WR_CHECK;
					end else if (!too_long) begin
						state_d = BS_HDR;
					end
				end
			end
			BS_WR_CHECK: state_d = (more && wr_fits) ? BS_WR_FETCH : BS_HDR;
			BS_WR_FETCH: state_d = BS_WR_CAPT;
			BS_WR_CAPT:  state_d = byte_last ? BS_WR_STORE : BS_WR_FETCH;
			BS_WR_STORE: state_d = BS_WR_CHECK;
			BS_HDR: begin
				if (out_push && hdr_last) begin
					state_d = cmd_q.is_wr ? BS_CRC_LO : BS_RD_CHECK;
				end
			end
			BS_RD_CHECK: state_d = more ? BS_RD_DATA : BS_CRC_LO;
			BS_RD_DATA:  state_d = BS_RD_EMIT;
			BS_RD_EMIT:  if (out_push && byte_last) state_d = BS_RD_CHECK;
			BS_CRC_LO:   if (out_push) state_d = BS_CRC_HI;
			BS_CRC_HI:   if (out_push) state_d = BS_IDLE;
			default:     state_d = BS_IDLE;
		endcase
	end

	// Outputs of each state.
	always_comb begin
		emit_valid = 1'b0;
		emit_byte  = 8'h00;
		emit_last  = 1'b0;
		cmd_pop    = 1'b0;
		st_we      = 4'b0000;
		pl_raddr   = PL_AW'(p_q + PL_CW'(j_q));
		unique case (state_q)
			BS_CLEAR:    st_we = 4'b1111;
			BS_IDLE:     cmd_pop = cmd_valid;
			BS_WR_STORE: st_we[k] = 1'b1;
			BS_HDR: begin
				emit_valid = 1'b1;
				emit_byte  = hdr_byte;
			end
			BS_RD_EMIT: begin
				emit_valid = 1'b1;
				emit_byte  = acc_q[31:24];
			end
			BS_CRC_LO: begin
				emit_valid = 1'b1;
				emit_byte  = crc_q[7:0];
			end
			BS_CRC_HI: begin
				emit_valid = 1'b1;
				emit_byte  = crc_q[15:8];
				emit_last  = 1'b1;
			end
			default: ;
		endcase
	end

	assign out_push         = emit_valid & ~outq_full;
	assign out_item.tx_byte = emit_byte;
	assign out_item.tx_last = emit_last;

	// Control registers, including the clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= RA_W'(clr_q + 1'b1);
			end
		end
	end

	// Working registers of the current request.
	always_ff @(posedge clk) begin
		unique case (state_q)
			BS_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd;
					r_q   <= END_W'(cmd.start);
					p_q   <= '0;
					crc_q <= CRC_INIT;
					h_q   <= '0;
				end
			end
			BS_WR_CHECK: j_q <= '0;
			BS_WR_CAPT: begin
				acc_q <= {acc_q[23:0], pl_rdata};
				j_q   <= 3'(j_q + 3'd1);
			end
			BS_WR_STORE: begin
				r_q <= END_W'(r_q + 1'b1);
				p_q <= PL_CW'(p_q + PL_CW'(wb));
			end
			BS_HDR: begin
				if (out_push) begin
					crc_q <= crc_byte(crc_q, emit_byte);
					h_q   <= 3'(h_q + 3'd1);
				end
			end
			BS_RD_DATA: begin
				j_q <= '0;
				unique case (k)
					2'd0:    acc_q <= {word_rd, 16'h0000};
					2'd1:    acc_q <= float_rd;
					2'd2:    acc_q <= {byte_rd, 24'h000000};
					default: acc_q <= {7'h00, flag_rd, 24'h000000};
				endcase
			end
			BS_RD_EMIT: begin
				if (out_push) begin
					crc_q <= crc_byte(crc_q, emit_byte);
					acc_q <= {acc_q[23:0], 8'h00};
					j_q   <= 3'(j_q + 3'd1);
					if (byte_last) begin
						r_q <= END_W'(r_q + 1'b1);
					end
				end
			end
			default: ;
		endcase
	end

	// Register stores: cleared by the sweep, then written by commits.
	assign st_waddr = clearing ? clr_q : r_q[RA_W-1:0];
	assign st_raddr = r_q[RA_W-1:0];

	mbrtu_ram #(.WIDTH(16), .DEPTH(REGION_SIZE)) u_word_store (
		.clk   (clk),
		.we    (st_we[0]),
		.waddr (st_waddr),
		.wdata (clearing ? 16'h0000 : acc_q[15:0]),
		.raddr (st_raddr),
		.rdata (word_rd)
	);

	mbrtu_ram #(.WIDTH(32), .DEPTH(REGION_SIZE)) u_float_store (
		.clk   (clk),
		.we    (st_we[1]),
		.waddr (st_waddr),
		.wdata (clearing ? 32'h0000_0000 : acc_q),
		.raddr (st_raddr),
		.rdata (float_rd)
	);

	mbrtu_ram #(.WIDTH(8), .DEPTH(REGION_SIZE)) u_byte_store (
		.clk   (clk),
		.we    (st_we[2]),
		.waddr (st_waddr),
		.wdata (clearing ? 8'h00 : acc_q[7:0]),
		.raddr (st_raddr),
		.rdata (byte_rd)
	);

	mbrtu_ram #(.WIDTH(1), .DEPTH(REGION_SIZE)) u_flag_store (
		.clk   (clk),
		.we    (st_we[3]),
		.waddr (st_waddr),
		.wdata (clearing ? 1'b0 : (acc_q[7:0] != 8'h00)),
		.raddr (st_raddr),
		.rdata (flag_rd)
	);

	// Nothing leaves the block during the clearing sweep.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !out_push)
		else $error("response item during store clearing");

	// A commit is finished before its response starts.
	a_commit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		stat.wr_busy |-> !emit_valid)
		else $error("response item during write commit");

	// The final CRC byte ends the response.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && emit_last) |=> (state_q == BS_IDLE))
		else $error("executor busy after the final item");

endmodule

// ===== src/mbrtu_outq.sv =====
// ----------------------------------------------------------------------------
// mbrtu_outq
// Response item queue that parts the executor from the receiver.
// ----------------------------------------------------------------------------
module mbrtu_outq
	import mbrtu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  resp_item_t din,
	output logic       full,
	input  logic       pop,
	output resp_item_t dout,
	output logic       empty
);

	localparam int AW = $clog2(OUTQ_DEPTH);

	resp_item_t    ent_q [OUTQ_DEPTH];
	logic [AW-1:0] rd_q;
	logic [AW-1:0] wr_q;
	logic [AW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == (AW+1)'(OUTQ_DEPTH));
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = ent_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= AW'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= AW'(rd_q + 1'b1);
			end
			cnt_q <= (AW+1)'(cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop));
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= din;
		end
	end

endmodule
